[hw/rtl/grid_diffusion_stencil_macros.svh]
// ----------------------------------------------------------------------------
// grid_diffusion_stencil assertion macros
// Shared concurrent assertion forms, clocked on clock.
// ----------------------------------------------------------------------------
`ifndef GRID_DIFFUSION_STENCIL_MACROS_SVH
`define GRID_DIFFUSION_STENCIL_MACROS_SVH

// same-cycle implication, off while reset is high
`define GDS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gds assertion failed");

// next-cycle implication, off while reset is high
`define GDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gds assertion failed");

// next-cycle implication that also checks across reset
`define GDS_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("gds assertion failed");

`endif

[hw/rtl/gds_pkg.sv]
// ----------------------------------------------------------------------------
// gds_pkg
// Types and constants shared by the diffusion stencil modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gds_pkg;

   localparam int VALUE_W     = 16;
   localparam int RATE_W      = 16;
   localparam int CFG_LEN_W   = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int SUM_W       = 18;
   localparam int WEIGHT_W    = 17;
   localparam int PROD_C_W    = 33;
   localparam int PROD_N_W    = 34;
   localparam int ACC_W       = 35;
   localparam int FRAC_W      = 16;
   localparam int TAP_COUNT   = 4;

   localparam logic [CFG_LEN_W-1:0] RESET_ROW_LENGTH = 9'd256;
   localparam logic [CFG_LEN_W-1:0] RESET_ROW_TOTAL  = 9'd256;
   localparam logic [RATE_W-1:0]    RESET_RATE       = 16'd6554;

   localparam logic [WEIGHT_W-1:0]  UNITY      = 17'h10000;
   localparam logic [ACC_W-1:0]     ROUND_HALF = 35'h8000;
   localparam logic [VALUE_W-1:0]   VALUE_MAX  = 16'hFFFF;

   // line store read ports
   localparam int TAP_CENTRE = 0;
   localparam int TAP_WEST   = 1;
   localparam int TAP_EAST   = 2;
   localparam int TAP_NORTH  = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_LENGTH     = 2'd0,
      CSR_ROW_TOTAL      = 2'd1,
      CSR_DIFFUSION_RATE = 2'd2
   } csr_index_type;

   // one stencil neighborhood, out-of-grid taps already zeroed
   typedef struct packed {
      logic [VALUE_W-1:0] centre;
      logic [VALUE_W-1:0] west;
      logic [VALUE_W-1:0] east;
      logic [VALUE_W-1:0] north;
      logic [VALUE_W-1:0] south;
      logic               frame_last;
   } taps_type;

endpackage

`default_nettype wire

[hw/rtl/gds_store.sv]
// ----------------------------------------------------------------------------
// gds_store
// One-write one-read line store with registered read and write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_store #(
   parameter int DEPTH = 512,
   parameter int WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // same-cycle write to the read address returns the new value
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/gds_scan.sv]
// ----------------------------------------------------------------------------
// gds_scan
// Config registers, raster position, line store and stencil tap register.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_scan #(
   parameter int MAX_ROW_LEN = 256,
   parameter int MAX_ROWS    = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [gds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [gds_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [gds_pkg::VALUE_W-1:0]        req_tdata,
   input  wire logic                               req_tuser,
   input  wire logic                               tap_ready,
   output logic                                    tap_valid,
   output gds_pkg::taps_type                       taps,
   output logic      [gds_pkg::RATE_W-1:0]         rate
);

   localparam int COL_W  = $clog2(MAX_ROW_LEN);
   localparam int LEN_W  = $clog2(MAX_ROW_LEN + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 1);
   localparam int ADDR_W = COL_W + 1;
   localparam int DEPTH  = 2 ** ADDR_W;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [gds_pkg::CFG_LEN_W-1:0] v);
      logic [LEN_W-1:0] res;
      if (v == '0) begin
         res = LEN_W'(1);
      end else if (int'(v) > MAX_ROW_LEN) begin
         res = LEN_W'(MAX_ROW_LEN);
      end else begin
         res = LEN_W'(v);
      end
      return res;
   endfunction

   function automatic logic [ROW_W-1:0] clamp_rows(input logic [gds_pkg::CFG_LEN_W-1:0] v);
      logic [ROW_W-1:0] res;
      if (v == '0) begin
         res = ROW_W'(1);
      end else if (int'(v) > MAX_ROWS) begin
         res = ROW_W'(MAX_ROWS);
      end else begin
         res = ROW_W'(v);
      end
      return res;
   endfunction

   logic [gds_pkg::CFG_LEN_W-1:0] row_length_ff, row_length_in;
   logic [gds_pkg::CFG_LEN_W-1:0] row_total_ff, row_total_in;
   logic [gds_pkg::RATE_W-1:0]    rate_ff, rate_in;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic              tap_valid_ff;
   gds_pkg::taps_type taps_ff, taps_in;

   logic [LEN_W-1:0] len_cur;
   logic [ROW_W-1:0] rows_cur, rows_nxt, last_row_nxt;
   logic [LEN_W:0]   col_inc;
   logic             row_phase, col_end, accept, produce, advance, up_ok;
   logic             row_phase_nxt, centre_bank_nxt, tap_take;

   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ADDR_W-1:0]             rd_addr [gds_pkg::TAP_COUNT];
   logic [gds_pkg::VALUE_W-1:0]   rd_data [gds_pkg::TAP_COUNT];

   // register writes
   always_comb begin
      row_length_in = row_length_ff;
      row_total_in  = row_total_ff;
      rate_in       = rate_ff;
      if (csr_wr_en) begin
         case (gds_pkg::csr_index_type'(csr_index))
            gds_pkg::CSR_ROW_LENGTH: begin
               row_length_in = csr_wdata[gds_pkg::CFG_LEN_W-1:0];
            end
            gds_pkg::CSR_ROW_TOTAL: begin
               row_total_in = csr_wdata[gds_pkg::CFG_LEN_W-1:0];
            end
            gds_pkg::CSR_DIFFUSION_RATE: begin
               rate_in = csr_wdata[gds_pkg::RATE_W-1:0];
            end
            default: begin
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   // position of the beat at the input
   always_comb begin
      len_cur   = clamp_len(row_length_ff);
      rows_cur  = clamp_rows(row_total_ff);
      rows_nxt  = clamp_rows(row_total_in);
      row_phase = row_ff < rows_cur;
      col_inc   = (LEN_W + 1)'(col_ff) + (LEN_W + 1)'(1);
      col_end   = col_inc >= (LEN_W + 1)'(len_cur);
      tap_take  = !tap_valid_ff || tap_ready;
      accept    = req_tvalid && tap_take;
      produce   = row_phase ? (!req_tuser && (row_ff != '0)) : 1'b1;
      // drain beats while rows still arrive leave the position alone
      advance   = accept && (!row_phase || !req_tuser);
      up_ok     = row_phase ? (row_ff >= ROW_W'(2)) : (rows_cur >= ROW_W'(2));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_phase ? (row_ff + ROW_W'(1)) : '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // read addresses follow the next position so data is ready on its beat
   always_comb begin
      row_phase_nxt   = row_in < rows_nxt;
      last_row_nxt    = rows_nxt - ROW_W'(1);
      centre_bank_nxt = row_phase_nxt ? ~row_in[0] : last_row_nxt[0];
      rd_addr[gds_pkg::TAP_CENTRE] = {centre_bank_nxt, col_in};
      rd_addr[gds_pkg::TAP_WEST]   = {centre_bank_nxt, col_in - COL_W'(1)};
      rd_addr[gds_pkg::TAP_EAST]   = {centre_bank_nxt, col_in + COL_W'(1)};
      rd_addr[gds_pkg::TAP_NORTH]  = {~centre_bank_nxt, col_in};
   end

   assign wr_en   = accept && row_phase && !req_tuser;
   assign wr_addr = {row_ff[0], col_ff};

   for (genvar g = 0; g < gds_pkg::TAP_COUNT; g++) begin : g_store
      gds_store #(
         .DEPTH (DEPTH),
         .WIDTH (gds_pkg::VALUE_W)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (req_tdata),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      taps_in.centre     = rd_data[gds_pkg::TAP_CENTRE];
      taps_in.west       = (col_ff != '0) ? rd_data[gds_pkg::TAP_WEST] : '0;
      taps_in.east       = !col_end ? rd_data[gds_pkg::TAP_EAST] : '0;
      taps_in.north      = up_ok ? rd_data[gds_pkg::TAP_NORTH] : '0;
      taps_in.south      = row_phase ? req_tdata : '0;
      taps_in.frame_last = !row_phase && col_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= gds_pkg::RESET_ROW_LENGTH;
         row_total_ff  <= gds_pkg::RESET_ROW_TOTAL;
         rate_ff       <= gds_pkg::RESET_RATE;
         col_ff        <= '0;
         row_ff        <= '0;
         tap_valid_ff  <= 1'b0;
      end else begin
         row_length_ff <= row_length_in;
         row_total_ff  <= row_total_in;
         rate_ff       <= rate_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         if (tap_take) begin
            tap_valid_ff <= accept && produce;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tap_take) begin
         taps_ff <= taps_in;
      end
   end

   assign req_tready = tap_take;
   assign tap_valid  = tap_valid_ff;
   assign taps       = taps_ff;
   assign rate       = rate_ff;

endmodule

`default_nettype wire

[hw/rtl/gds_blend.sv]
// ----------------------------------------------------------------------------
// gds_blend
// Weighted sum of centre and neighbors, rounding, saturation, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_blend (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        tap_valid,
   output logic                             tap_ready,
   input  wire gds_pkg::taps_type           taps,
   input  wire logic [gds_pkg::RATE_W-1:0]  rate,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [gds_pkg::VALUE_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);

   logic [gds_pkg::SUM_W-1:0]    sum;
   logic [gds_pkg::WEIGHT_W-1:0] weight_c;
   logic [gds_pkg::PROD_C_W-1:0] prod_c_ff, prod_c_in;
   logic [gds_pkg::PROD_N_W-1:0] prod_n_ff, prod_n_in;
   logic                         prod_last_ff;
   logic                         prod_valid_ff;
   logic                         prod_take, out_take;

   logic [gds_pkg::ACC_W-1:0]               acc;
   logic [gds_pkg::ACC_W-gds_pkg::FRAC_W-1:0] rounded;
   logic [gds_pkg::VALUE_W-1:0]             value_in;
   logic [gds_pkg::VALUE_W-1:0]             rsp_data_ff;
   logic                                    rsp_last_ff;
   logic                                    rsp_valid_ff;

   assign out_take  = !rsp_valid_ff || rsp_tready;
   assign prod_take = !prod_valid_ff || out_take;
   assign tap_ready = prod_take;

   always_comb begin
      sum = gds_pkg::SUM_W'(taps.north) + gds_pkg::SUM_W'(taps.south)
          + gds_pkg::SUM_W'(taps.west) + gds_pkg::SUM_W'(taps.east);
      weight_c  = gds_pkg::UNITY - gds_pkg::WEIGHT_W'(rate);
      prod_c_in = gds_pkg::PROD_C_W'(weight_c) * gds_pkg::PROD_C_W'(taps.centre);
      prod_n_in = gds_pkg::PROD_N_W'(rate) * gds_pkg::PROD_N_W'(sum);
   end

   // round half up, then clip at the top of unsigned Q16.0
   always_comb begin
      acc = gds_pkg::ACC_W'(prod_c_ff) + gds_pkg::ACC_W'(prod_n_ff) + gds_pkg::ROUND_HALF;
      rounded = acc[gds_pkg::ACC_W-1:gds_pkg::FRAC_W];
      if (rounded[gds_pkg::ACC_W-gds_pkg::FRAC_W-1:gds_pkg::VALUE_W] != '0) begin
         value_in = gds_pkg::VALUE_MAX;
      end else begin
         value_in = rounded[gds_pkg::VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (prod_take) begin
            prod_valid_ff <= tap_valid;
         end
         if (out_take) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_take) begin
         prod_c_ff    <= prod_c_in;
         prod_n_ff    <= prod_n_in;
         prod_last_ff <= taps.frame_last;
      end
      if (out_take) begin
         rsp_data_ff <= value_in;
         rsp_last_ff <= prod_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[hw/rtl/grid_diffusion_stencil.sv]
// A result passes the tap, product and result registers after its beat is taken.
// Throughput: one beat per cycle while rsp_tready keeps up; the line store has one
// read port per stored tap, takes its write in the same cycle; nothing iterates.
// Reset (synchronous, active high) clears the raster position and all valid flags
// and restores row_length 256, row_total 256, diffusion_rate 6554.
// Line store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// grid_diffusion_stencil
// Five-point diffusion over a raster-ordered grid, results one row behind.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_diffusion_stencil #(
   parameter int MAX_ROW_LEN = 256,
   parameter int MAX_ROWS    = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [gds_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [gds_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [15:0]                     req_tdata,  // [15:0] cell_value
   input  wire logic                            req_tuser,  // [0] drain
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [15:0]                     rsp_tdata,  // [15:0] new_value
   output logic                                 rsp_tlast   // frame_last
);

   logic                       tap_valid;
   logic                       tap_ready;
   gds_pkg::taps_type          taps;
   logic [gds_pkg::RATE_W-1:0] rate;

   gds_scan #(
      .MAX_ROW_LEN (MAX_ROW_LEN),
      .MAX_ROWS    (MAX_ROWS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .tap_ready  (tap_ready),
      .tap_valid  (tap_valid),
      .taps       (taps),
      .rate       (rate)
   );

   gds_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .tap_valid  (tap_valid),
      .tap_ready  (tap_ready),
      .taps       (taps),
      .rate       (rate),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[hw/rtl/gds_checker.sv]
// ----------------------------------------------------------------------------
// gds_checker
// Port-level checks on the diffusion stencil, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_diffusion_stencil_macros.svh"

module gds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a waiting result beat stays put
   `GDS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `GDS_ASSERT_NEXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))

   // input only backs up when a finished result is stuck at the output
   `GDS_ASSERT_NOW(a_stall_source, !req_tready, rsp_tvalid && !rsp_tready)

   // reset empties the pipeline
   `GDS_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_tvalid && req_tready)

endmodule

bind grid_diffusion_stencil gds_checker u_gds_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
